// ===== rtl/core/bsr_pkg.sv =====
package bsr_pkg;

   localparam int MAX_BOUNDARY = 32;
   localparam int QUEUE_DEPTH  = 4;

   localparam int LEN_WIDTH      = 6;
   localparam int CSR_WIDTH      = 64;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int BOUNDARY_BITS  = 256;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LENGTH     = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BYTES_LO   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BYTES_MID  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BYTES_UPPER = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BYTES_TOP  = 3'd4;

   typedef struct packed {
      logic       end_flag;
      logic       byte_valid;
      logic [7:0] out_byte;
   } result_type;

endpackage

// ===== rtl/core/bsr_queue.sv =====
module bsr_queue #(
   parameter int DEPTH = bsr_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  bsr_pkg::result_type  push_item,
   output logic                 full,
   input  logic                 pop,
   output bsr_pkg::result_type  pop_item,
   output logic                 empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   bsr_pkg::result_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign full     = (fill_ff == NW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/bsr_front.sv =====
module bsr_front #(
   parameter int MAX_BOUNDARY = bsr_pkg::MAX_BOUNDARY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          data_byte,
   input  logic                                stream_end,
   input  logic                                csr_we,
   input  logic [bsr_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [bsr_pkg::CSR_WIDTH-1:0]       csr_wdata,
   output logic                                push_valid,
   output bsr_pkg::result_type                 push_item,
   input  logic                                q_full
);

   localparam int CW = $clog2(MAX_BOUNDARY + 1);
   localparam int IW = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;

   logic [bsr_pkg::LEN_WIDTH-1:0]     len_ff;
   logic [bsr_pkg::BOUNDARY_BITS-1:0] boundary_ff;
   logic [7:0]    window_ff [MAX_BOUNDARY];
   logic [7:0]    window_in [MAX_BOUNDARY];
   logic [7:0]    byte_at   [MAX_BOUNDARY];
   logic [MAX_BOUNDARY-1:0] eq;
   logic [CW-1:0] count_ff, count_in;
   logic          flush_ff, flush_in;
   logic [CW-1:0] eff_len;
   logic          accept, full, match;

   assign req_tready = !flush_ff && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (len_ff == '0) begin
         eff_len = CW'(1);
      end else if (len_ff > bsr_pkg::LEN_WIDTH'(MAX_BOUNDARY)) begin
         eff_len = CW'(MAX_BOUNDARY);
      end else begin
         eff_len = CW'(len_ff);
      end
   end

   // window as it stands with the new byte placed at the fill position
   always_comb begin
      for (int i = 0; i < MAX_BOUNDARY; i++) begin
         byte_at[i] = (CW'(i) == count_ff) ? data_byte : window_ff[i];
         eq[i] = (byte_at[i] == boundary_ff[8*i +: 8]) || (CW'(i) >= eff_len);
      end
   end

   assign full  = ((count_ff + CW'(1)) == eff_len);
   assign match = &eq;

   always_comb begin
      window_in  = window_ff;
      count_in   = count_ff;
      flush_in   = flush_ff;
      push_valid = 1'b0;
      push_item  = '0;
      if (flush_ff) begin
         if (!q_full) begin
            push_valid = 1'b1;
            if (count_ff == '0) begin
               push_item.end_flag = 1'b1;
               flush_in = 1'b0;
            end else begin
               push_item.out_byte   = window_ff[0];
               push_item.byte_valid = 1'b1;
               push_item.end_flag   = (count_ff == CW'(1));
               for (int i = 0; i < MAX_BOUNDARY - 1; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               count_in = count_ff - CW'(1);
               flush_in = (count_ff != CW'(1));
            end
         end
      end else if (accept) begin
         flush_in = stream_end;
         if (full) begin
            if (match) begin
               count_in = '0;
            end else begin
               push_valid           = 1'b1;
               push_item.out_byte   = byte_at[0];
               push_item.byte_valid = 1'b1;
               for (int i = 0; i < MAX_BOUNDARY - 1; i++) begin
                  window_in[i] = byte_at[i+1];
               end
               count_in = eff_len - CW'(1);
            end
         end else begin
            window_in[count_ff[IW-1:0]] = data_byte;
            count_in = count_ff + CW'(1);
         end
      end
      if (csr_we && csr_index == bsr_pkg::CSR_LENGTH) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         flush_ff    <= 1'b0;
         len_ff      <= bsr_pkg::LEN_WIDTH'(1);
         boundary_ff <= '0;
      end else begin
         count_ff <= count_in;
         flush_ff <= flush_in;
         if (csr_we) begin
            unique case (csr_index)
               bsr_pkg::CSR_LENGTH: begin
                  len_ff <= csr_wdata[bsr_pkg::LEN_WIDTH-1:0];
               end
               bsr_pkg::CSR_BYTES_LO: begin
                  boundary_ff[63:0] <= csr_wdata;
               end
               bsr_pkg::CSR_BYTES_MID: begin
                  boundary_ff[127:64] <= csr_wdata;
               end
               bsr_pkg::CSR_BYTES_UPPER: begin
                  boundary_ff[191:128] <= csr_wdata;
               end
               bsr_pkg::CSR_BYTES_TOP: begin
                  boundary_ff[255:192] <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

// ===== rtl/core/bsr_back.sv =====
module bsr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  bsr_pkg::result_type q_item,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output bsr_pkg::result_type rsp_item
);

   logic                valid_ff, valid_in;
   bsr_pkg::result_type item_ff;

   assign q_pop      = (!valid_ff || rsp_tready) && !q_empty;
   assign valid_in   = q_pop || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
   end

endmodule

// ===== rtl/core/boundary_string_remover.sv =====
// channel   direction  transfer contents
// req_      in         tdata[7:0] data_byte, tlast stream_end
// rsp_      out        tdata[7:0] out_byte, tuser byte_valid, tlast end_flag
// csr_      in         write enable, register index, 64-bit write data
//
// one byte per cycle outside flushes and while the result queue has
// room; the window compare is one parallel compare per position
// a byte marked last flushes the pending window at one result per cycle
// while the result queue has room; req_tready is low during the flush
// a short result queue and an output register part the two sides
// synchronous active-high reset; no clearing pass, the window needs none
module boundary_string_remover #(
   parameter int MAX_BOUNDARY = bsr_pkg::MAX_BOUNDARY,
   parameter int QUEUE_DEPTH  = bsr_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // data_byte
   input  logic                               req_tlast,   // stream_end
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // out_byte
   output logic                               rsp_tuser,   // byte_valid
   output logic                               rsp_tlast,   // end_flag
   input  logic                               csr_we,
   input  logic [bsr_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [bsr_pkg::CSR_WIDTH-1:0]      csr_wdata
);

   logic                push_valid;
   bsr_pkg::result_type push_item;
   logic                q_full;
   logic                q_empty;
   logic                q_pop;
   bsr_pkg::result_type q_item;
   bsr_pkg::result_type rsp_item;

   bsr_front #(
      .MAX_BOUNDARY(MAX_BOUNDARY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .data_byte  (req_tdata),
      .stream_end (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_item  (push_item),
      .q_full     (q_full)
   );

   bsr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .pop_item   (q_item),
      .empty      (q_empty)
   );

   bsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = rsp_item.out_byte;
   assign rsp_tuser = rsp_item.byte_valid;
   assign rsp_tlast = rsp_item.end_flag;

endmodule
